[sv/tgr_pkg.sv]
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types and constants of the touch gesture recogniser.
// ----------------------------------------------------------------------------
package tgr_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 2;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_ROTATION      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_WAIT_FOR_IRQ  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SWIPE_MIN     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_MS = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_TAP_MAX_MS    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_TAP_MS = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_TAP_RADIUS    = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_SMOOTH_WEIGHT = 3'd7;

	// quarter-turn codes
	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	typedef enum logic [2:0] {
		GEST_NONE,
		GEST_TAP,
		GEST_DOUBLE_TAP,
		GEST_LONG_PRESS,
		GEST_LEFT,
		GEST_RIGHT,
		GEST_UP,
		GEST_DOWN
	} gesture_t;

	typedef struct packed {
		logic [1:0]  rotation;
		logic        wait_for_interrupt;
		logic [11:0] swipe_min_distance;
		logic [15:0] long_press_ms;
		logic [15:0] tap_max_ms;
		logic [15:0] double_tap_ms;
		logic [11:0] tap_radius;
		logic [3:0]  smooth_weight;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		rotation:           2'd3,
		wait_for_interrupt: 1'b1,
		swipe_min_distance: 12'd30,
		long_press_ms:      16'd600,
		tap_max_ms:         16'd250,
		double_tap_ms:      16'd300,
		tap_radius:         12'd20,
		smooth_weight:      4'd6
	};

	// classified poll as it travels from front to back
	typedef struct packed {
		logic        ignored;
		logic        touched;
		logic [15:0] x;
		logic [15:0] y;
		logic [31:0] now;
	} item_t;

	typedef struct packed {
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic        is_touched;
		logic        just_pressed;
		logic        just_released;
		logic        moved;
		gesture_t    gesture;
	} report_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_SUM,
		SEQ_MUL,
		SEQ_FIX,
		SEQ_COMMIT
	} seq_state_t;

endpackage

[sv/tgr_poll_if.sv]
// ----------------------------------------------------------------------------
// tgr_poll_if
// Touch poll channel: valid/ready and the raw poll fields.
// ----------------------------------------------------------------------------
interface tgr_poll_if;
	logic        valid;
	logic        ready;
	logic        irq_seen;
	logic [3:0]  touch_points;
	logic [11:0] raw_x;
	logic [11:0] raw_y;
	logic [31:0] now_ms;

	modport source (output valid, irq_seen, touch_points, raw_x, raw_y, now_ms, input ready);
	modport sink (input valid, irq_seen, touch_points, raw_x, raw_y, now_ms, output ready);
endinterface

[sv/tgr_report_if.sv]
// ----------------------------------------------------------------------------
// tgr_report_if
// Gesture report channel: valid/ready and the event fields.
// ----------------------------------------------------------------------------
interface tgr_report_if;
	logic        valid;
	logic        ready;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic        is_touched;
	logic        just_pressed;
	logic        just_released;
	logic        moved;
	logic [2:0]  gesture;

	modport source (output valid, pos_x, pos_y, is_touched, just_pressed, just_released,
		moved, gesture, input ready);
	modport sink (input valid, pos_x, pos_y, is_touched, just_pressed, just_released,
		moved, gesture, output ready);
endinterface

[sv/touch_gesture_recognizer.sv]
// ----------------------------------------------------------------------------
// touch_gesture_recognizer
// Touch poll to gesture event converter with rotation and smoothing.
// ----------------------------------------------------------------------------
// Every accepted poll beat yields exactly one report beat, in order. The back
// end sequencer works each poll through four steps (smoothing sums, reciprocal
// multiply, quotient fix-up, decision and commit) and takes the next poll
// from the queue only when it commits the current one. The front end keeps
// accepting into a two-entry queue while a poll is being worked and a finished
// report waits in the output register. Configuration writes must only be
// issued while nothing is in flight.
module touch_gesture_recognizer #(
	parameter int PANEL_WIDTH        = 240,
	parameter int PANEL_HEIGHT       = 320,
	parameter int SMOOTH_DENOMINATOR = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	tgr_poll_if.sink                          poll,
	tgr_report_if.source                      report,
	input  logic                              cfg_we,
	input  logic [tgr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tgr_pkg::CFG_DATA_W-1:0]    cfg_data
);

	tgr_pkg::cfg_t  cfg_q;
	logic           q_ready, q_push, q_pop, q_valid;
	tgr_pkg::item_t push_item, head_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= tgr_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tgr_pkg::CFG_ROTATION:      cfg_q.rotation           <= cfg_data[1:0];
				tgr_pkg::CFG_WAIT_FOR_IRQ:  cfg_q.wait_for_interrupt <= cfg_data[0];
				tgr_pkg::CFG_SWIPE_MIN:     cfg_q.swipe_min_distance <= cfg_data[11:0];
				tgr_pkg::CFG_LONG_PRESS_MS: cfg_q.long_press_ms      <= cfg_data;
				tgr_pkg::CFG_TAP_MAX_MS:    cfg_q.tap_max_ms         <= cfg_data;
				tgr_pkg::CFG_DOUBLE_TAP_MS: cfg_q.double_tap_ms      <= cfg_data;
				tgr_pkg::CFG_TAP_RADIUS:    cfg_q.tap_radius         <= cfg_data[11:0];
				tgr_pkg::CFG_SMOOTH_WEIGHT: cfg_q.smooth_weight      <= cfg_data[3:0];
			endcase
		end
	end

	tgr_front #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_front (
		.poll    (poll),
		.cfg     (cfg_q),
		.q_ready (q_ready),
		.q_push  (q_push),
		.q_item  (push_item)
	);

	tgr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (push_item),
		.push_ready (q_ready),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_item  (head_item)
	);

	tgr_back #(
		.SMOOTH_DENOMINATOR (SMOOTH_DENOMINATOR)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_item  (head_item),
		.q_pop   (q_pop),
		.report  (report)
	);

endmodule

[sv/tgr_front.sv]
// ----------------------------------------------------------------------------
// tgr_front
// Accepts polls, applies interrupt gating and rotation, pushes to the queue.
// ----------------------------------------------------------------------------
module tgr_front #(
	parameter int PANEL_WIDTH  = 240,
	parameter int PANEL_HEIGHT = 320
) (
	tgr_poll_if.sink        poll,
	input  tgr_pkg::cfg_t   cfg,
	input  logic            q_ready,
	output logic            q_push,
	output tgr_pkg::item_t  q_item
);

	localparam logic [15:0] PW16 = 16'(PANEL_WIDTH);
	localparam logic [15:0] PH16 = 16'(PANEL_HEIGHT);

	logic [15:0] rx16;
	logic [15:0] ry16;

	assign poll.ready = q_ready;
	assign q_push     = poll.valid && q_ready;

	assign rx16 = {4'd0, poll.raw_x};
	assign ry16 = {4'd0, poll.raw_y};

	always_comb begin
		q_item.ignored = cfg.wait_for_interrupt && !poll.irq_seen;
		q_item.touched = (poll.touch_points != 4'd0);
		q_item.now     = poll.now_ms;
		// panel offsets wrap at 16 bits
		unique case (cfg.rotation)
			tgr_pkg::ROT_0: begin
				q_item.x = rx16;
				q_item.y = ry16;
			end
			tgr_pkg::ROT_90: begin
				q_item.x = ry16;
				q_item.y = PW16 - rx16;
			end
			tgr_pkg::ROT_180: begin
				q_item.x = PW16 - rx16;
				q_item.y = PH16 - ry16;
			end
			tgr_pkg::ROT_270: begin
				q_item.x = PH16 - ry16;
				q_item.y = rx16;
			end
		endcase
	end

endmodule

[sv/tgr_queue.sv]
// ----------------------------------------------------------------------------
// tgr_queue
// Short FIFO of classified polls between front and back.
// ----------------------------------------------------------------------------
module tgr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tgr_pkg::item_t  push_item,
	output logic            push_ready,
	input  logic            pop,
	output logic            head_valid,
	output tgr_pkg::item_t  head_item
);

	localparam int DEPTH = tgr_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	tgr_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign push_ready = (count_q != CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

endmodule

[sv/tgr_back.sv]
// ----------------------------------------------------------------------------
// tgr_back
// Four-step sequencer: smoothing sums, reciprocal multiply, quotient fix-up,
// then gesture decision, state update and report register.
// ----------------------------------------------------------------------------
module tgr_back #(
	parameter int SMOOTH_DENOMINATOR = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tgr_pkg::cfg_t   cfg,
	input  logic            q_valid,
	input  tgr_pkg::item_t  q_item,
	output logic            q_pop,
	tgr_report_if.source    report
);

	localparam int DW = $clog2(SMOOTH_DENOMINATOR + 1);
	localparam int WW = (DW > 4) ? DW : 4;
	localparam int NW = 16 + DW;
	// floor(2^NW / D): estimate is at most one below the true quotient
	localparam logic [NW-1:0] RECIP = NW'((64'd1 << NW) / SMOOTH_DENOMINATOR);
	localparam logic [WW-1:0] DEN_W = WW'(SMOOTH_DENOMINATOR);
	localparam logic [NW-1:0] DEN_N = NW'(SMOOTH_DENOMINATOR);

	function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	tgr_pkg::seq_state_t state_q, state_d;
	logic commit_ok;
	logic do_commit;

	tgr_pkg::item_t item_q;

	// gesture state
	logic        was_touched_q;
	logic [15:0] last_x_q, last_y_q;
	logic [15:0] smoothed_x_q, smoothed_y_q;
	logic [15:0] press_x_q, press_y_q;
	logic [31:0] press_time_q;
	logic        long_seen_q;
	logic        tap_wait_q;
	logic [31:0] tap_time_q;

	// per-beat working registers
	logic [NW-1:0] nx_q, ny_q;
	logic [15:0]   ax_q, ay_q;
	logic          same_q, tap_fast_q, dtap_in_q, long_due_q;
	logic [15:0]   qx_q, qy_q;
	logic [15:0]   smx_q, smy_q;

	logic                   rpt_valid_q;
	tgr_pkg::report_t       rpt_q;

	// ---------------- sequencer ----------------
	assign commit_ok = !rpt_valid_q || report.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tgr_pkg::SEQ_IDLE: begin
				if (q_valid) state_d = tgr_pkg::SEQ_SUM;
			end
			tgr_pkg::SEQ_SUM:  state_d = tgr_pkg::SEQ_MUL;
			tgr_pkg::SEQ_MUL:  state_d = tgr_pkg::SEQ_FIX;
			tgr_pkg::SEQ_FIX:  state_d = tgr_pkg::SEQ_COMMIT;
			tgr_pkg::SEQ_COMMIT: begin
				if (commit_ok) state_d = q_valid ? tgr_pkg::SEQ_SUM : tgr_pkg::SEQ_IDLE;
			end
			default: state_d = tgr_pkg::SEQ_IDLE;
		endcase
	end

	always_comb begin
		do_commit = (state_q == tgr_pkg::SEQ_COMMIT) && commit_ok;
		q_pop     = q_valid && ((state_q == tgr_pkg::SEQ_IDLE) || do_commit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgr_pkg::SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
	end

	// ---------------- sum step ----------------
	logic [WW-1:0] sw, w, dmw;
	logic [NW-1:0] nx_d, ny_d;
	logic [31:0]   dt_press, dt_tap;
	logic [15:0]   ax_d, ay_d;
	logic          press_now;

	always_comb begin
		sw   = WW'(cfg.smooth_weight);
		w    = (sw > DEN_W) ? DEN_W : sw;
		dmw  = DEN_W - w;
		nx_d = NW'(smoothed_x_q) * NW'(w) + NW'(item_q.x) * NW'(dmw);
		ny_d = NW'(smoothed_y_q) * NW'(w) + NW'(item_q.y) * NW'(dmw);
		dt_press  = item_q.now - press_time_q;
		dt_tap    = item_q.now - tap_time_q;
		ax_d      = abs_diff(last_x_q, press_x_q);
		ay_d      = abs_diff(last_y_q, press_y_q);
		press_now = item_q.touched && !was_touched_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == tgr_pkg::SEQ_SUM) begin
			nx_q       <= nx_d;
			ny_q       <= ny_d;
			ax_q       <= ax_d;
			ay_q       <= ay_d;
			same_q     <= (ax_d < {4'd0, cfg.tap_radius}) && (ay_d < {4'd0, cfg.tap_radius});
			tap_fast_q <= dt_press < {16'd0, cfg.tap_max_ms};
			dtap_in_q  <= dt_tap < {16'd0, cfg.double_tap_ms};
			// a fresh press restarts the hold timer at zero
			long_due_q <= press_now ? (cfg.long_press_ms == 16'd0)
				: (dt_press >= {16'd0, cfg.long_press_ms});
		end
	end

	// ---------------- reciprocal multiply ----------------
	logic [2*NW-1:0] prod_x, prod_y;

	assign prod_x = (2*NW)'(nx_q) * (2*NW)'(RECIP);
	assign prod_y = (2*NW)'(ny_q) * (2*NW)'(RECIP);

	always_ff @(posedge clk) begin
		if (state_q == tgr_pkg::SEQ_MUL) begin
			qx_q <= prod_x[NW+15:NW];
			qy_q <= prod_y[NW+15:NW];
		end
	end

	// ---------------- quotient fix-up ----------------
	logic [NW-1:0] rem_x, rem_y;

	assign rem_x = nx_q - NW'(qx_q) * DEN_N;
	assign rem_y = ny_q - NW'(qy_q) * DEN_N;

	always_ff @(posedge clk) begin
		if (state_q == tgr_pkg::SEQ_FIX) begin
			smx_q <= (rem_x >= DEN_N) ? qx_q + 16'd1 : qx_q;
			smy_q <= (rem_y >= DEN_N) ? qy_q + 16'd1 : qy_q;
		end
	end

	// ---------------- decision ----------------
	logic        was_d, long_d, tap_wait_d;
	logic [15:0] last_x_d, last_y_d, sm_x_d, sm_y_d, press_x_d, press_y_d;
	logic [31:0] press_time_d, tap_time_d;
	tgr_pkg::report_t rpt_d;
	logic [15:0] smd16;
	logic        press, release_now, still, lps_eff, done;

	always_comb begin
		was_d        = was_touched_q;
		long_d       = long_seen_q;
		tap_wait_d   = tap_wait_q;
		last_x_d     = last_x_q;
		last_y_d     = last_y_q;
		sm_x_d       = smoothed_x_q;
		sm_y_d       = smoothed_y_q;
		press_x_d    = press_x_q;
		press_y_d    = press_y_q;
		press_time_d = press_time_q;
		tap_time_d   = tap_time_q;
		smd16        = {4'd0, cfg.swipe_min_distance};
		press        = item_q.touched && !was_touched_q;
		release_now  = !item_q.touched && was_touched_q;
		still        = (abs_diff(smx_q, item_q.x) < smd16) && (abs_diff(smy_q, item_q.y) < smd16);
		lps_eff      = press ? 1'b0 : long_seen_q;
		done         = 1'b0;

		rpt_d.pos_x         = item_q.touched ? item_q.x : last_x_q;
		rpt_d.pos_y         = item_q.touched ? item_q.y : last_y_q;
		rpt_d.is_touched    = item_q.touched;
		rpt_d.just_pressed  = press;
		rpt_d.just_released = release_now;
		rpt_d.moved         = 1'b0;
		rpt_d.gesture       = tgr_pkg::GEST_NONE;

		if (item_q.ignored) begin
			rpt_d = '0;
		end else begin
			if (item_q.touched) begin
				was_d    = 1'b1;
				last_x_d = item_q.x;
				last_y_d = item_q.y;
				sm_x_d   = smx_q;
				sm_y_d   = smy_q;
				long_d   = lps_eff;
				if (press) begin
					press_x_d    = item_q.x;
					press_y_d    = item_q.y;
					press_time_d = item_q.now;
				end
				if (!lps_eff && still && long_due_q) begin
					long_d        = 1'b1;
					rpt_d.gesture = tgr_pkg::GEST_LONG_PRESS;
				end else begin
					rpt_d.moved = 1'b1;
				end
			end
			if (release_now) begin
				was_d = 1'b0;
				if ((ax_q > smd16) || (ay_q > smd16)) begin
					done = 1'b1;
					if (ax_q > ay_q) begin
						rpt_d.gesture = (last_x_q > press_x_q) ? tgr_pkg::GEST_RIGHT
							: tgr_pkg::GEST_LEFT;
					end else begin
						rpt_d.gesture = (last_y_q > press_y_q) ? tgr_pkg::GEST_DOWN
							: tgr_pkg::GEST_UP;
					end
				end else if (tap_fast_q && !long_seen_q) begin
					done = 1'b1;
					if (tap_wait_q && dtap_in_q && same_q) begin
						tap_wait_d    = 1'b0;
						rpt_d.gesture = tgr_pkg::GEST_DOUBLE_TAP;
					end else begin
						// report this tap and arm the double-tap window in case a second one follows
						tap_wait_d    = 1'b1;
						tap_time_d    = item_q.now;
						last_x_d      = press_x_q;
						last_y_d      = press_y_q;
						rpt_d.gesture = tgr_pkg::GEST_TAP;
					end
				end
			end
			// window expired: end the wait and report a tap, may override a long press
			if (!done && tap_wait_q && !dtap_in_q) begin
				tap_wait_d    = 1'b0;
				rpt_d.gesture = tgr_pkg::GEST_TAP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_touched_q <= 1'b0;
			last_x_q      <= '0;
			last_y_q      <= '0;
			smoothed_x_q  <= '0;
			smoothed_y_q  <= '0;
			press_x_q     <= '0;
			press_y_q     <= '0;
			press_time_q  <= '0;
			long_seen_q   <= 1'b0;
			tap_wait_q    <= 1'b0;
			tap_time_q    <= '0;
		end else if (do_commit) begin
			was_touched_q <= was_d;
			last_x_q      <= last_x_d;
			last_y_q      <= last_y_d;
			smoothed_x_q  <= sm_x_d;
			smoothed_y_q  <= sm_y_d;
			press_x_q     <= press_x_d;
			press_y_q     <= press_y_d;
			press_time_q  <= press_time_d;
			long_seen_q   <= long_d;
			tap_wait_q    <= tap_wait_d;
			tap_time_q    <= tap_time_d;
		end
	end

	// ---------------- report register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (do_commit) begin
			rpt_valid_q <= 1'b1;
		end else if (report.ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_commit) begin
			rpt_q <= rpt_d;
		end
	end

	assign report.valid         = rpt_valid_q;
	assign report.pos_x         = rpt_q.pos_x;
	assign report.pos_y         = rpt_q.pos_y;
	assign report.is_touched    = rpt_q.is_touched;
	assign report.just_pressed  = rpt_q.just_pressed;
	assign report.just_released = rpt_q.just_released;
	assign report.moved         = rpt_q.moved;
	assign report.gesture       = rpt_q.gesture;

endmodule

[sv/tgr_checker.sv]
// ----------------------------------------------------------------------------
// tgr_checker
// Port-level checks of the gesture recogniser, bound to the top level.
// ----------------------------------------------------------------------------
module tgr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        poll_valid,
	input logic        poll_ready,
	input logic        report_valid,
	input logic        report_ready,
	input logic [15:0] pos_x,
	input logic [15:0] pos_y,
	input logic        is_touched,
	input logic        just_pressed,
	input logic        just_released,
	input logic        moved,
	input logic [2:0]  gesture
);

	localparam int MAX_HELD = tgr_pkg::QUEUE_DEPTH + 2;
	localparam int OW       = $clog2(MAX_HELD + 1);

	logic [OW-1:0] held_q;
	logic          in_beat, out_beat;

	assign in_beat  = poll_valid && poll_ready;
	assign out_beat = report_valid && report_ready;

	// polls accepted but not yet reported
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else begin
			held_q <= held_q + OW'(in_beat) - OW'(out_beat);
		end
	end

	a_report_held: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && !report_ready |=> report_valid)
		else $error("report beat dropped while stalled");

	a_report_stable: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && !report_ready |=> $stable(pos_x) && $stable(pos_y)
			&& $stable(is_touched) && $stable(just_pressed) && $stable(just_released)
			&& $stable(moved) && $stable(gesture))
		else $error("report payload changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid |-> held_q != '0)
		else $error("report without an outstanding poll");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		held_q == OW'(MAX_HELD) |-> !poll_ready)
		else $error("poll accepted with no room left");

	a_release_gestures: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && (gesture == tgr_pkg::GEST_DOUBLE_TAP || gesture == tgr_pkg::GEST_LEFT
			|| gesture == tgr_pkg::GEST_RIGHT || gesture == tgr_pkg::GEST_UP
			|| gesture == tgr_pkg::GEST_DOWN) |-> just_released && !is_touched)
		else $error("swipe or double tap reported without a release");

endmodule

bind touch_gesture_recognizer tgr_checker u_tgr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.poll_valid    (poll.valid),
	.poll_ready    (poll.ready),
	.report_valid  (report.valid),
	.report_ready  (report.ready),
	.pos_x         (report.pos_x),
	.pos_y         (report.pos_y),
	.is_touched    (report.is_touched),
	.just_pressed  (report.just_pressed),
	.just_released (report.just_released),
	.moved         (report.moved),
	.gesture       (report.gesture)
);
